// File: rtl/tbcu_pkg.sv
package tbcu_pkg;

  localparam int unsigned NumCodes  = 7;
  localparam int unsigned CodeW     = 3;
  localparam int unsigned SymW      = 8;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned MaxCodes  = 3;

  typedef logic [CodeW-1:0] code_t;
  typedef logic [SymW-1:0]  sym_t;

  localparam code_t EndCode = code_t'(7);

  typedef enum logic [1:0] {
    PH_0 = 2'd0,
    PH_1 = 2'd1,
    PH_2 = 2'd2
  } phase_t;

endpackage

// File: rtl/three_bit_code_unpacker.sv
// Unpacks a byte stream of 3-bit codes, most significant bit first, eight
// codes in every three bytes. Bytes arrive on the in_ channel; each byte gives
// two or three results on the out_ channel, one per cycle, with the symbol in
// out_tdata, the end flag in out_tuser and the final result of a byte marked
// by out_tlast. Codes 0 to 6 read the seven-entry symbol table that the cfg_
// port writes (index 0 to 6, other indexes ignored, always ready). Code 7
// gives one result with the end flag and symbol 0; the rest of that byte and
// every later byte are taken and dropped until reset.
// A byte is held in a code buffer and its results step through the output
// register, so the first result of a byte passes the code buffer and then
// the output register before it appears. The single result channel paces the
// input: the next byte is taken in the cycle that the last result of the
// current one moves out. A stalled receiver holds the output register and the
// code buffer, which then stops taking bytes. Reset clears the phase, the
// carried bits, the end state, both valid flags and the symbol table.
module three_bit_code_unpacker (
  input  logic                     clk,
  input  logic                     rst_n,
  // Input item: [7:0] packed_byte.
  input  logic                     in_tvalid,
  output logic                     in_tready,
  input  logic [7:0]               in_tdata,
  // Result item: [7:0] symbol.
  output logic                     out_tvalid,
  input  logic                     out_tready,
  output logic [7:0]               out_tdata,
  // [0] end_marker.
  output logic [0:0]               out_tuser,
  output logic                     out_tlast,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [tbcu_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [7:0]               cfg_data
);
  import tbcu_pkg::*;

  sym_t   dict_r [NumCodes];

  phase_t phase_r, phase_nxt;
  logic [1:0] carry_r, carry_nxt;
  logic   ended_r, ended_nxt;

  code_t  buf_codes_r [MaxCodes];
  code_t  dec_codes   [MaxCodes];
  logic [1:0] buf_n_r, dec_n;
  logic [1:0] buf_idx_r;
  logic   buf_valid_r;

  logic   out_valid_r;
  sym_t   out_sym_r;
  logic   out_end_r;
  logic   out_last_r;

  logic   in_acc;
  logic   dec_has_end;
  logic   move;
  code_t  cur_code;
  logic   cur_end;
  logic   cur_last;
  sym_t   cur_sym;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NumCodes; i++) begin
        dict_r[i] <= '0;
      end
    end else if (cfg_valid && (cfg_index < CfgIdxW'(NumCodes))) begin
      dict_r[cfg_index] <= cfg_data;
    end
  end

  // Split the byte into codes according to the phase of the 3-byte group.
  always_comb begin
    dec_codes[0] = in_tdata[7:5];
    dec_codes[1] = in_tdata[4:2];
    dec_codes[2] = '0;
    dec_n        = 2'd2;
    carry_nxt    = in_tdata[1:0];
    phase_nxt    = PH_1;
    unique case (phase_r)
      PH_1: begin
        dec_codes[0] = {carry_r, in_tdata[7]};
        dec_codes[1] = in_tdata[6:4];
        dec_codes[2] = in_tdata[3:1];
        dec_n        = 2'd3;
        carry_nxt    = {1'b0, in_tdata[0]};
        phase_nxt    = PH_2;
      end
      PH_2: begin
        dec_codes[0] = {carry_r[0], in_tdata[7:6]};
        dec_codes[1] = in_tdata[5:3];
        dec_codes[2] = in_tdata[2:0];
        dec_n        = 2'd3;
        carry_nxt    = 2'b00;
        phase_nxt    = PH_0;
      end
      default: begin
      end
    endcase
    dec_has_end = (dec_codes[0] == EndCode) || (dec_codes[1] == EndCode) ||
                  ((dec_n == 2'd3) && (dec_codes[2] == EndCode));
    ended_nxt   = ended_r || dec_has_end;
  end

  assign cur_code = buf_codes_r[buf_idx_r];
  assign cur_end  = (cur_code == EndCode);
  assign cur_last = cur_end || ((buf_idx_r + 2'd1) == buf_n_r);
  assign cur_sym  = cur_end ? '0 : dict_r[cur_code];
  assign move     = buf_valid_r && (!out_valid_r || out_tready);

  assign in_tready = !buf_valid_r || (move && cur_last);
  assign in_acc    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_0;
      carry_r     <= '0;
      ended_r     <= 1'b0;
      buf_valid_r <= 1'b0;
      buf_idx_r   <= '0;
    end else begin
      if (in_acc && !ended_r) begin
        phase_r     <= phase_nxt;
        carry_r     <= carry_nxt;
        ended_r     <= ended_nxt;
        buf_valid_r <= 1'b1;
        buf_idx_r   <= '0;
      end else if (move) begin
        if (cur_last) begin
          buf_valid_r <= 1'b0;
        end else begin
          buf_idx_r <= buf_idx_r + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && !ended_r) begin
      for (int i = 0; i < MaxCodes; i++) begin
        buf_codes_r[i] <= dec_codes[i];
      end
      buf_n_r <= dec_n;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (move) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      out_sym_r  <= cur_sym;
      out_end_r  <= cur_end;
      out_last_r <= cur_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_sym_r;
  assign out_tuser  = out_end_r;
  assign out_tlast  = out_last_r;

  a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    buf_valid_r |-> (buf_idx_r < buf_n_r))
    else $error("code buffer index beyond its code count");

  a_end_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[0]) |-> (out_tlast && (out_tdata == '0)))
    else $error("end result without last flag or with nonzero symbol");

  a_no_load_after_end: assert property (@(posedge clk) disable iff (!rst_n)
    (ended_r && !buf_valid_r) |=> !buf_valid_r)
    else $error("code buffer loaded after the stream ended");

endmodule
